// ----- hw/rtl/ulcd_pkg.sv -----
package ulcd_pkg;

  // Line store and length counter sizes
  localparam int unsigned MATCH_CHARS = 12;
  localparam int unsigned LINE_MAX    = 2048;
  localparam int unsigned LEN_W       = 12;
  localparam int unsigned IDX_W       = $clog2(MATCH_CHARS);

  // Queue between collector and decoder
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] LINE_END   = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Keyword patterns: string literals, right-aligned, first character in the highest used byte
  localparam int unsigned KW_MAX    = 8;
  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned KW_LEN_W  = 4;

  typedef logic [8*KW_MAX-1:0] kw_pat_t;

  localparam kw_pat_t KW_HELP  = "help";
  localparam kw_pat_t KW_CLS   = "cls";
  localparam kw_pat_t KW_SEND  = "send";
  localparam kw_pat_t KW_NET   = " net";
  localparam kw_pat_t KW_CAT   = " cat";
  localparam kw_pat_t KW_STATE = "state";

  localparam kw_pat_t STATE_WORDS [NUM_WORDS] = '{
    " init", " idle", " pre", " ready", " servo", " manual", " fault", " down"
  };
  localparam logic [KW_LEN_W-1:0] STATE_LENS [NUM_WORDS] = '{
    4'd5, 4'd5, 4'd4, 4'd6, 4'd6, 4'd7, 4'd6, 4'd5
  };

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_HELP  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_STATE = 3'd4
  } cmd_e;

  localparam logic [3:0] PARAM_NONE = 4'd0;
  localparam logic [3:0] PARAM_HIT  = 4'd1;
  localparam logic [3:0] PARAM_NET  = 4'd1;
  localparam logic [3:0] PARAM_CAT  = 4'd2;

  typedef logic [MATCH_CHARS-1:0][7:0] line_t;

  // One finished line, classified by length
  typedef struct packed {
    line_t chars;
    logic  len_is_3;
    logic  len_is_4;
    logic  len_is_8;
  } line_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Compare a keyword at a position; letters fold case, a space must be exact,
  // positions past the store never match
  function automatic logic kw_match(input line_t ch, input int unsigned pos,
                                    input kw_pat_t pat, input logic [KW_LEN_W-1:0] len);
    logic        hit;
    logic [7:0]  want;
    logic [7:0]  got;
    int unsigned idx;
    hit = 1'b1;
    for (int unsigned i = 0; i < KW_MAX; i++) begin
      if (i < int'(len)) begin
        idx  = pos + i;
        want = pat[8*(int'(len) - 1 - i) +: 8];
        got  = (idx < MATCH_CHARS) ? ch[IDX_W'(idx)] : 8'h00;
        if (want == CHAR_SPACE) begin
          if (got != CHAR_SPACE) hit = 1'b0;
        end else if ((got | CHAR_SPACE) != want) begin
          hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

endpackage

// ----- hw/rtl/ulcd_if.sv -----
interface ulcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ulcd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd_code;
  logic [3:0] param_code;

  modport source (output valid, output cmd_code, output param_code, input ready);
  modport sink (input valid, input cmd_code, input param_code, output ready);
endinterface

// ----- hw/rtl/uart_line_command_decoder_top.sv -----
// UART line command decoder. Takes one received byte per cycle on in_ch and
// collects it into a 12-character line store with a saturating length count;
// a carriage return (0x0d) ends the line and yields exactly one item on
// out_ch with a command code (0 none, 1 help, 2 clear, 3 send, 4 state) and a
// parameter code, other bytes yield nothing. The collector hands each finished
// line to a two-entry queue and the keyword decoder drains it into an output
// register, so out_ch.valid rises once the line is queued, popped and loaded
// there. Throughput is one byte per cycle, including a carriage return on
// every cycle, as long as out_ch takes a result each cycle; when out_ch
// stalls, input is held off only once two finished lines wait in the queue.
module uart_line_command_decoder_top (
  input logic clk,
  input logic rst_n,
  ulcd_in_if.sink    in_ch,
  ulcd_out_if.source out_ch
);
  import ulcd_pkg::*;

  q_stat_t   q_stat;
  line_rec_t push_rec;
  line_rec_t head_rec;
  logic      push;
  logic      pop;

  ulcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_rx_byte (in_ch.rx_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_rec   (push_rec)
  );

  ulcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  ulcd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_rec       (head_rec),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_cmd_code   (out_ch.cmd_code),
    .out_param_code (out_ch.param_code)
  );

endmodule

// ----- hw/rtl/ulcd_front.sv -----
module ulcd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  ulcd_pkg::q_stat_t   q_stat,
  output logic                push,
  output ulcd_pkg::line_rec_t push_rec
);
  import ulcd_pkg::*;

  line_t            chars_r, chars_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             accept;
  logic             is_end;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign is_end   = (in_rx_byte == LINE_END);
  assign push     = accept && is_end;

  // Classify the finished line by length
  always_comb begin
    push_rec.chars    = chars_r;
    push_rec.len_is_3 = (len_r == LEN_W'(3));
    push_rec.len_is_4 = (len_r == LEN_W'(4));
    push_rec.len_is_8 = (len_r == LEN_W'(8));
  end

  // Store the byte, advance the saturating count, clear on line end
  always_comb begin
    chars_nxt = chars_r;
    len_nxt   = len_r;
    if (accept) begin
      if (is_end) begin
        chars_nxt = '0;
        len_nxt   = '0;
      end else begin
        if (len_r < LEN_W'(MATCH_CHARS)) chars_nxt[len_r[IDX_W-1:0]] = in_rx_byte;
        if (len_r < LEN_W'(LINE_MAX)) len_nxt = len_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r <= '0;
      len_r   <= '0;
    end else begin
      chars_r <= chars_nxt;
      len_r   <= len_nxt;
    end
  end

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_MAX))
    else $error("line length above saturation limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (len_r == '0) && (chars_r == '0))
    else $error("line store not cleared after line end");

endmodule

// ----- hw/rtl/ulcd_queue.sv -----
module ulcd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ulcd_pkg::line_rec_t push_rec,
  input  logic                pop,
  output ulcd_pkg::line_rec_t head_rec,
  output ulcd_pkg::q_stat_t   q_stat
);
  import ulcd_pkg::*;

  line_rec_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_rec     = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(QUEUE_DEPTH)) &&
    ((cnt_r == '0) || (cnt_r == CNT_W'(QUEUE_DEPTH)) || (wr_ptr_r != rd_ptr_r)))
    else $error("queue occupancy out of step with pointers");

endmodule

// ----- hw/rtl/ulcd_back.sv -----
module ulcd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ulcd_pkg::line_rec_t head_rec,
  input  ulcd_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_cmd_code,
  output logic [3:0]          out_param_code
);
  import ulcd_pkg::*;

  logic       valid_r, valid_nxt;
  logic [2:0] cmd_r;
  logic [3:0] param_r;
  cmd_e       cmd_dec;
  logic [3:0] param_dec;

  assign pop            = !q_stat.empty && (!valid_r || out_ready);
  assign out_valid      = valid_r;
  assign out_cmd_code   = cmd_r;
  assign out_param_code = param_r;

  // Decode the line at the queue head; a later rule overrides an earlier one
  always_comb begin
    cmd_dec   = CMD_NONE;
    param_dec = PARAM_NONE;
    if (head_rec.len_is_4 && kw_match(head_rec.chars, 0, KW_HELP, 4'd4)) begin
      cmd_dec   = CMD_HELP;
      param_dec = PARAM_HIT;
    end
    if (head_rec.len_is_3 && kw_match(head_rec.chars, 0, KW_CLS, 4'd3)) begin
      cmd_dec   = CMD_CLEAR;
      param_dec = PARAM_HIT;
    end
    if (head_rec.len_is_8 && kw_match(head_rec.chars, 0, KW_SEND, 4'd4)) begin
      cmd_dec = CMD_SEND;
      if (kw_match(head_rec.chars, 4, KW_NET, 4'd4)) param_dec = PARAM_NET;
      else if (kw_match(head_rec.chars, 4, KW_CAT, 4'd4)) param_dec = PARAM_CAT;
    end
    if (kw_match(head_rec.chars, 0, KW_STATE, 4'd5)) begin
      cmd_dec = CMD_STATE;
      // Scan from the last word down so the first match wins
      for (int k = NUM_WORDS - 1; k >= 0; k--) begin
        if (kw_match(head_rec.chars, 5, STATE_WORDS[k], STATE_LENS[k])) begin
          param_dec = 4'(k + 1);
        end
      end
    end
  end

  // Hold the result until taken, load the next one on pop
  always_comb begin
    valid_nxt = valid_r;
    if (pop) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r   <= cmd_dec;
      param_r <= param_dec;
    end
  end

  a_param_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (cmd_r == CMD_NONE)) |-> (param_r == PARAM_NONE))
    else $error("parameter code without command");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("popped line did not produce a result");

endmodule

// ----- tb/tb_uart_line_command_decoder_top.sv -----
module tb_uart_line_command_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ulcd_pkg::*;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] param;
  } decoded_cmd_t;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned PHASE_BYTES = 140;

  logic clk;
  logic rst_n;

  ulcd_in_if  in_ch ();
  ulcd_out_if out_ch ();

  uart_line_command_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bytes waiting to be offered, and command results still owed by the block
  byte_t        rx_pending [$];
  decoded_cmd_t expected_cmds [$];

  // Shadow copy of the line store and length count
  byte_t            line_store [MATCH_CHARS];
  logic [LEN_W-1:0] line_count;

  string state_names [8] = '{" init", " idle", " pre", " ready",
                             " servo", " manual", " fault", " down"};

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned recv_hold_len;
  int unsigned hold_done;
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  bit          in_taken;

  // Read a stored character; anything past the store reads as zero
  function automatic byte_t stored_char(int unsigned pos);
    return (pos < MATCH_CHARS) ? line_store[pos] : 8'h00;
  endfunction

  // Letters fold case, a space must be exact
  function automatic bit word_at(int unsigned pos, string w);
    byte_t want;
    byte_t got;
    for (int i = 0; i < w.len(); i++) begin
      want = w[i];
      got  = stored_char(pos + i);
      if (want == CHAR_SPACE) begin
        if (got != CHAR_SPACE) return 1'b0;
      end else if ((got | CHAR_SPACE) != want) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic decoded_cmd_t decode_line();
    decoded_cmd_t r;
    r.cmd   = CMD_NONE;
    r.param = PARAM_NONE;
    if (line_count == 4 && word_at(0, "help")) begin
      r.cmd   = CMD_HELP;
      r.param = PARAM_HIT;
    end
    if (line_count == 3 && word_at(0, "cls")) begin
      r.cmd   = CMD_CLEAR;
      r.param = PARAM_HIT;
    end
    if (line_count == 8 && word_at(0, "send")) begin
      r.cmd = CMD_SEND;
      if (word_at(4, " net")) r.param = PARAM_NET;
      else if (word_at(4, " cat")) r.param = PARAM_CAT;
    end
    if (word_at(0, "state")) begin
      r.cmd = CMD_STATE;
      for (int k = 0; k < 8; k++) begin
        if (word_at(5, state_names[k])) begin
          r.param = 4'(k + 1);
          break;
        end
      end
    end
    return r;
  endfunction

  // Store or count one accepted byte; on a line end, owe one result and clear
  task automatic absorb_byte(byte_t b);
    if (b != LINE_END) begin
      if (line_count < MATCH_CHARS) line_store[line_count] = b;
      if (line_count < LINE_MAX) line_count++;
    end else begin
      expected_cmds.push_back(decode_line());
      foreach (line_store[i]) line_store[i] = 8'h00;
      line_count = '0;
    end
  endtask

  function automatic byte_t noise_byte();
    byte_t v;
    v = 8'($urandom_range(0, 255));
    if (v == LINE_END) v = 8'h8d;
    return v;
  endfunction

  function automatic byte_t random_case(byte_t c);
    if ((c | CHAR_SPACE) >= "a" && (c | CHAR_SPACE) <= "z" && $urandom_range(0, 1))
      return c ^ CHAR_SPACE;
    return c;
  endfunction

  function automatic string pick_keyword();
    case ($urandom_range(0, 9))
      0: return "help";
      1: return "cls";
      2: return "send net";
      3: return "send cat";
      4: return $sformatf("send %c%c%c", $urandom_range(97, 122),
                          $urandom_range(97, 122), $urandom_range(97, 122));
      5: return "state";
      6: return {"state", state_names[$urandom_range(0, 7)], "zz"};
      7: return $sformatf("state %c%c%c", $urandom_range(97, 122),
                          $urandom_range(97, 122), $urandom_range(97, 122));
      default: return {"state", state_names[$urandom_range(0, 7)]};
    endcase
  endfunction

  // Queue text, optionally in mixed case, and close the line
  task automatic add_text(string s, bit mix_case);
    byte_t c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      rx_pending.push_back(mix_case ? random_case(c) : c);
    end
    rx_pending.push_back(LINE_END);
  endtask

  // Queue a line with one raw byte between two pieces of text
  task automatic add_with_byte(string head, byte_t mid, string tail);
    for (int i = 0; i < head.len(); i++) rx_pending.push_back(head[i]);
    rx_pending.push_back(mid);
    for (int i = 0; i < tail.len(); i++) rx_pending.push_back(tail[i]);
    rx_pending.push_back(LINE_END);
  endtask

  // Mostly keyword lines with random case and damage, the rest noise or a keyword followed by noise
  task automatic add_random_line();
    byte_t       body [$];
    string       s;
    int unsigned kind;
    int unsigned pos;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      s = pick_keyword();
      for (int i = 0; i < s.len(); i++) body.push_back(random_case(s[i]));
      if ($urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, body.size() - 1);
        case ($urandom_range(0, 2))
          0: body[pos] = 8'h00;
          1: body[pos] = body[pos] ^ 8'h40;
          default: body[pos] = noise_byte();
        endcase
      end
      if ($urandom_range(0, 7) == 0) body.push_back(noise_byte());
      if ($urandom_range(0, 7) == 0) void'(body.pop_back());
    end else if (kind < 95) begin
      repeat ($urandom_range(0, 14)) body.push_back(noise_byte());
    end else begin
      s = pick_keyword();
      for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
      repeat ($urandom_range(5, 30)) body.push_back(noise_byte());
    end
    foreach (body[i]) rx_pending.push_back(body[i]);
    rx_pending.push_back(LINE_END);
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = rx_pending.size() + PHASE_BYTES;
    while (rx_pending.size() < target) add_random_line();
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Hold off the receiver for a fixed stretch once asked, else stall at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_done < recv_hold_len) begin
      hold_done++;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer pending bytes; keep an item steady until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'h00;
    end else begin
      if (in_taken) void'(rx_pending.pop_front());
      if (!in_ch.valid || in_taken) begin
        if (rx_pending.size() != 0 && ($urandom_range(0, 99) >= send_idle_pct)) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= (in_taken) ? rx_pending[0] : rx_pending[0];
        end else begin
          in_ch.valid   <= 1'b0;
          in_ch.rx_byte <= noise_byte();
        end
      end
    end
  end

  // Predict on accepted bytes and check each accepted result in order
  always @(posedge clk) begin
    decoded_cmd_t exp_cmd;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) absorb_byte(in_ch.rx_byte);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected result: cmd_code %0d, param_code %0d",
               out_ch.cmd_code, out_ch.param_code);
        mismatch_cnt++;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (out_ch.cmd_code !== exp_cmd.cmd) begin
          $error("cmd_code: expected %0d, actual %0d", exp_cmd.cmd, out_ch.cmd_code);
          mismatch_cnt++;
        end
        if (out_ch.param_code !== exp_cmd.param) begin
          $error("param_code: expected %0d, actual %0d", exp_cmd.param, out_ch.param_code);
          mismatch_cnt++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_uart_line_command_decoder_top: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_len  = 0;
    hold_done      = 0;
    cycle_cnt      = 0;
    mismatch_cnt   = 0;
    in_taken       = 1'b0;
    line_count     = '0;
    foreach (line_store[i]) line_store[i] = 8'h00;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines: every command and word, case folding, exact space
    add_text("help", 1'b0);
    add_text("HeLP", 1'b0);
    add_text("cls", 1'b1);
    add_text("send net", 1'b1);
    add_text("SEND CAT", 1'b0);
    add_text("send dog", 1'b0);
    foreach (state_names[k]) add_text({"state", state_names[k]}, 1'b1);
    add_text("state", 1'b0);
    add_text("state xyz", 1'b0);
    add_text("state preamble", 1'b0);
    add_text("state manualXYZ", 1'b0);
    add_with_byte("send", 8'h00, "net");
    add_with_byte("state", 8'h00, "init");
    add_with_byte("hel", 8'h50, "");
    // Wrong lengths, short lines reading zero, empty line
    add_text("help ", 1'b0);
    add_text("hel", 1'b0);
    add_text("stat", 1'b0);
    add_text("", 1'b0);
    add_with_byte("", 8'h00, "");
    add_with_byte("", 8'hff, "");
    add_with_byte("", 8'h7f, "");
    add_with_byte("", 8'h80, "");
    // Long line: bytes past the store are counted but not kept
    rx_pending.push_back("h");
    rx_pending.push_back("e");
    rx_pending.push_back("l");
    rx_pending.push_back("p");
    repeat (100) rx_pending.push_back(noise_byte());
    rx_pending.push_back(LINE_END);
    add_text("cls", 1'b0);
    wait_drained();

    run_random(0, 0);
    run_random(74, 0);
    run_random(0, 74);
    run_random(30, 30);

    // Back-pressure: receiver holds off while short lines keep arriving
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_len  = 150;
    repeat (40) begin
      if ($urandom_range(0, 1)) add_text("cls", 1'b1);
      else add_text("help", 1'b1);
    end
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && expected_cmds.size() == 0) begin
      $display("tb_uart_line_command_decoder_top: done, clean");
    end else begin
      $display("tb_uart_line_command_decoder_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ulcd_pkg.sv
hw/rtl/ulcd_if.sv
hw/rtl/ulcd_front.sv
hw/rtl/ulcd_queue.sv
hw/rtl/ulcd_back.sv
hw/rtl/uart_line_command_decoder_top.sv
tb/tb_uart_line_command_decoder_top.sv
